>>> sv/hss_pkg.sv
`default_nettype none

package hss_pkg;

    localparam int HALF_STEPS_DEFAULT = 2048;
    localparam logic [7:0] LEFT_LIMIT_RESET = 8'd60;

    localparam int POS_W   = 13;
    localparam int STEPS_W = 13;
    localparam int ANGLE_W = 9;
    localparam int LIMIT_W = 8;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 8;

    localparam logic signed [POS_W-1:0] POS_MAX = 13'sd4095;
    localparam logic signed [POS_W-1:0] POS_MIN = -13'sd4096;
    localparam logic [STEPS_W-1:0] STEPS_MAX = 13'd8191;

    localparam logic [CFG_IDX_W-1:0] CFG_CALIBRATED = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LEFT_LIMIT = 2'd1;

    typedef enum logic [1:0] {
        KIND_TICK = 2'd0,
        KIND_MODE = 2'd1,
        KIND_MOVE = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        MODE_LEFT  = 2'd0,
        MODE_RIGHT = 2'd1,
        MODE_STOP  = 2'd2,
        MODE_HOLD  = 2'd3
    } mode_t;

    typedef struct packed {
        logic [1:0]         kind;
        mode_t              mode;
        logic [ANGLE_W-1:0] angle_deg;
    } item_t;

    typedef struct packed {
        logic               calibrated;
        logic [LIMIT_W-1:0] left_limit_deg;
    } cfg_t;

    localparam logic [3:0] RIGHT_SEQ [8] = '{4'h1, 4'h3, 4'h2, 4'h6, 4'h4, 4'hC, 4'h8, 4'h9};
    localparam logic [3:0] LEFT_SEQ  [8] = '{4'h2, 4'h3, 4'h1, 4'h9, 4'h8, 4'hC, 4'h4, 4'h6};

endpackage

`default_nettype wire

>>> sv/hss_ifs.sv
`default_nettype none

interface hss_cmd_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [1:0] mode;
    logic [8:0] angle_deg;

    modport source (output valid, output kind, output mode, output angle_deg, input ready);
    modport sink (input valid, input kind, input mode, input angle_deg, output ready);
endinterface

interface hss_status_if;
    logic               valid;
    logic               ready;
    logic [3:0]         coils;
    logic signed [12:0] position;
    logic               running;
    logic               move_done;

    modport source (output valid, output coils, output position, output running,
                    output move_done, input ready);
    modport sink (input valid, input coils, input position, input running,
                  input move_done, output ready);
endinterface

`default_nettype wire

>>> sv/hss_cfg_regs.sv
`default_nettype none

module hss_cfg_regs
    import hss_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                       cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_CALIBRATED: cfg_next.calibrated = cfg_data[0];
                CFG_LEFT_LIMIT: cfg_next.left_limit_deg = cfg_data[LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.calibrated     <= 1'b0;
            cfg_reg.left_limit_deg <= LEFT_LIMIT_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

>>> sv/hss_in_stage.sv
`default_nettype none

module hss_in_stage
    import hss_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    hss_cmd_if.sink    cmd,
    input  wire logic  adv,
    output logic       s1_valid,
    output item_t      s1_item
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;
    logic  take;

    // The stage empties whenever the result side moves, so a new request can
    // land in the same cycle the previous one leaves.
    assign take = !valid_reg || adv;
    assign cmd.ready = take;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
            valid_next = cmd.valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (take && cmd.valid)
        begin
            item_reg.kind      <= cmd.kind;
            item_reg.mode      <= mode_t'(cmd.mode);
            item_reg.angle_deg <= cmd.angle_deg;
        end
    end

    assign s1_valid = valid_reg;
    assign s1_item  = item_reg;

endmodule

`default_nettype wire

>>> sv/hss_core.sv
`default_nettype none

module hss_core
    import hss_pkg::*;
#(
    parameter int HALF_STEPS_PER_HALF_TURN = HALF_STEPS_DEFAULT
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  s1_valid,
    input  wire item_t s1_item,
    input  wire cfg_t  cfg,
    output logic       adv,
    hss_status_if.source status
);

    localparam int HS_W   = $clog2(HALF_STEPS_PER_HALF_TURN + 1);
    localparam int LIM_W  = LIMIT_W + HS_W;
    localparam int LCMP_W = (LIM_W + 1 > 22) ? LIM_W + 1 : 22;
    localparam int MV_W   = (ANGLE_W + HS_W > 21) ? ANGLE_W + HS_W : 21;

    logic                      run_reg,    run_next;
    mode_t                     dir_reg,    dir_next;
    logic [2:0]                phase_reg,  phase_next;
    logic signed [POS_W-1:0]   pos_reg,    pos_next;
    logic                      active_reg, active_next;
    logic [STEPS_W-1:0]        steps_reg,  steps_next;
    logic [ANGLE_W-1:0]        target_reg, target_next;
    logic [3:0]                coils_reg,  coils_next;
    logic                      out_valid_reg;
    logic                      done_reg, done_next;

    logic                      fire;
    logic                      stepped;
    logic                      left_ok;
    logic [STEPS_W-1:0]        steps_inc;
    logic signed [LCMP_W-1:0]  pos_scaled;
    logic signed [LCMP_W-1:0]  lim_scaled;
    logic [MV_W-1:0]           steps_scaled;
    logic [MV_W-1:0]           tgt_scaled;

    assign adv  = !out_valid_reg || status.ready;
    assign fire = s1_valid && adv;

    // Left steps are allowed while position*180 < limit*half_steps.
    assign pos_scaled = LCMP_W'(pos_reg) * LCMP_W'(180);
    assign lim_scaled = signed'(LCMP_W'(cfg.left_limit_deg)) * LCMP_W'(HALF_STEPS_PER_HALF_TURN);
    assign left_ok    = pos_scaled < lim_scaled;

    assign steps_inc    = (steps_reg == STEPS_MAX) ? steps_reg : steps_reg + 1'b1;
    assign steps_scaled = MV_W'(steps_inc) * MV_W'(180);
    assign tgt_scaled   = MV_W'(target_reg) * MV_W'(HALF_STEPS_PER_HALF_TURN);

    always_comb
    begin
        run_next    = run_reg;
        dir_next    = dir_reg;
        phase_next  = phase_reg;
        pos_next    = pos_reg;
        active_next = active_reg;
        steps_next  = steps_reg;
        target_next = target_reg;
        coils_next  = coils_reg;
        done_next   = 1'b0;
        stepped     = 1'b0;

        case (s1_item.kind)
            KIND_TICK:
            begin
                if (run_reg)
                begin
                    if (dir_reg == MODE_RIGHT && !pos_reg[POS_W-1])
                    begin
                        stepped    = 1'b1;
                        coils_next = RIGHT_SEQ[phase_reg];
                        phase_next = phase_reg + 3'd1;
                        if (!cfg.calibrated)
                            pos_next = '0;
                        else if (pos_reg != POS_MIN)
                            pos_next = pos_reg - 13'sd1;
                    end
                    else if (dir_reg == MODE_LEFT && left_ok)
                    begin
                        stepped    = 1'b1;
                        coils_next = LEFT_SEQ[phase_reg];
                        phase_next = phase_reg + 3'd1;
                        if (pos_reg != POS_MAX)
                            pos_next = pos_reg + 13'sd1;
                    end
                end
                else if (dir_reg == MODE_STOP)
                begin
                    coils_next = '0;
                end

                if (stepped && active_reg)
                begin
                    if (steps_scaled >= tgt_scaled)
                    begin
                        steps_next  = '0;
                        active_next = 1'b0;
                        coils_next  = '0;
                        run_next    = 1'b0;
                        done_next   = 1'b1;
                    end
                    else
                    begin
                        steps_next = steps_inc;
                    end
                end
            end
            KIND_MODE:
            begin
                dir_next = s1_item.mode;
                if (!run_reg && (s1_item.mode == MODE_LEFT || s1_item.mode == MODE_RIGHT))
                    run_next = 1'b1;
                else if (run_reg && s1_item.mode == MODE_STOP)
                    run_next = 1'b0;
            end
            KIND_MOVE:
            begin
                target_next = s1_item.angle_deg;
                active_next = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg       <= 1'b0;
            dir_reg       <= MODE_RIGHT;
            phase_reg     <= '0;
            pos_reg       <= '0;
            active_reg    <= 1'b0;
            steps_reg     <= '0;
            target_reg    <= '0;
            coils_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv)
                out_valid_reg <= s1_valid;
            if (fire)
            begin
                run_reg    <= run_next;
                dir_reg    <= dir_next;
                phase_reg  <= phase_next;
                pos_reg    <= pos_next;
                active_reg <= active_next;
                steps_reg  <= steps_next;
                target_reg <= target_next;
                coils_reg  <= coils_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
            done_reg <= done_next;
    end

    // The state registers hold exactly the status after the last request.
    assign status.valid     = out_valid_reg;
    assign status.coils     = coils_reg;
    assign status.position  = pos_reg;
    assign status.running   = run_reg;
    assign status.move_done = done_reg;

endmodule

`default_nettype wire

>>> sv/half_step_stepper_sequencer.sv
// A request passes the input register, then the status register, whose output is its status.
// The block takes one request per cycle; the only stall is a held status output.
// The input register and the status register each pass one request a cycle unless stalled.
// Reset clears the motor state: stopped, right mode, phase and position zero,
// coils off, no angle move; calibration off and left limit 60 degrees.
`default_nettype none

module half_step_stepper_sequencer
    import hss_pkg::*;
#(
    parameter int HALF_STEPS_PER_HALF_TURN = HALF_STEPS_DEFAULT
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    hss_cmd_if.sink                    cmd,
    hss_status_if.source               status,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t  cfg;
    logic  adv;
    logic  s1_valid;
    item_t s1_item;

    hss_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    hss_in_stage u_in (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .adv      (adv),
        .s1_valid (s1_valid),
        .s1_item  (s1_item)
    );

    hss_core #(
        .HALF_STEPS_PER_HALF_TURN (HALF_STEPS_PER_HALF_TURN)
    ) u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .s1_valid (s1_valid),
        .s1_item  (s1_item),
        .cfg      (cfg),
        .adv      (adv),
        .status   (status)
    );

    // A completed angle move always leaves the motor stopped with coils off.
    a_done_stops: assert property (@(posedge clk) disable iff (!rst_n)
        status.valid && status.move_done |-> !status.running && status.coils == 4'd0)
        else $error("move completion left the motor running or coils driven");

    // A request waiting in the input register is never dropped on a stall.
    a_s1_holds: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid && !adv |=> s1_valid)
        else $error("input register lost a request while stalled");

    // A request that moves forward always produces a status word.
    a_s1_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid && adv |=> status.valid)
        else $error("request advanced without producing a status");

endmodule

`default_nettype wire

>>> tb/tb_half_step_stepper_sequencer.sv
`default_nettype none

module tb_half_step_stepper_sequencer;
    import hss_pkg::*;

    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_HI = 2'd3;
    localparam int QUIET_LIMIT = 400;
    localparam int N_PHASES = 6;
    localparam int PHASE_REQUESTS = 90;

    localparam logic [3:0] CW_PATTERN [8] = '{4'h1, 4'h3, 4'h2, 4'h6, 4'h4, 4'hC, 4'h8, 4'h9};
    localparam logic [3:0] CCW_PATTERN [8] = '{4'h2, 4'h3, 4'h1, 4'h9, 4'h8, 4'hC, 4'h4, 4'h6};

    localparam logic PHASE_CAL [N_PHASES] = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1};
    localparam logic [7:0] PHASE_LIMIT [N_PHASES] = '{8'd60, 8'd180, 8'd0, 8'd180, 8'd3, 8'd0};

    typedef struct packed {
        logic [3:0]         coils;
        logic signed [12:0] position;
        logic               running;
        logic               move_done;
    } motor_status_t;

    typedef enum logic { ROW_REQ, ROW_REG } row_e;

    // A request row uses code as the kind and value as the angle; a register
    // row uses code as the register index and value as the write data.
    typedef struct packed {
        row_e          what;
        logic [1:0]    code;
        mode_t         mode;
        logic [8:0]    value;
        logic          typed;
        motor_status_t want;
    } plan_row_t;

    localparam motor_status_t NO_WANT = '0;
    localparam int N_PLAN = 31;

    localparam plan_row_t PLAN [N_PLAN] = '{
        '{ROW_REQ, KIND_TICK,   MODE_HOLD,  9'd0,   1'b1, '{4'h0, 13'sd0, 1'b0, 1'b0}},
        '{ROW_REQ, KIND_UNUSED, MODE_HOLD,  9'd511, 1'b1, '{4'h0, 13'sd0, 1'b0, 1'b0}},
        '{ROW_REQ, KIND_MODE,   MODE_RIGHT, 9'd0,   1'b1, '{4'h0, 13'sd0, 1'b1, 1'b0}},
        '{ROW_REQ, KIND_TICK,   MODE_LEFT,  9'd511, 1'b1, '{4'h1, 13'sd0, 1'b1, 1'b0}},
        '{ROW_REQ, KIND_TICK,   MODE_LEFT,  9'd0,   1'b0, NO_WANT},
        '{ROW_REQ, KIND_MODE,   MODE_LEFT,  9'd0,   1'b0, NO_WANT},
        '{ROW_REQ, KIND_TICK,   MODE_STOP,  9'd0,   1'b0, NO_WANT},
        '{ROW_REQ, KIND_TICK,   MODE_HOLD,  9'd0,   1'b0, NO_WANT},
        '{ROW_REQ, KIND_MODE,   MODE_HOLD,  9'd0,   1'b0, NO_WANT},
        '{ROW_REQ, KIND_TICK,   MODE_LEFT,  9'd0,   1'b0, NO_WANT},
        '{ROW_REQ, KIND_MODE,   MODE_STOP,  9'd0,   1'b0, NO_WANT},
        '{ROW_REQ, KIND_TICK,   MODE_LEFT,  9'd0,   1'b0, NO_WANT},
        '{ROW_REQ, KIND_MOVE,   MODE_LEFT,  9'd0,   1'b0, NO_WANT},
        '{ROW_REQ, KIND_MODE,   MODE_RIGHT, 9'd0,   1'b0, NO_WANT},
        '{ROW_REQ, KIND_TICK,   MODE_LEFT,  9'd0,   1'b0, NO_WANT},
        '{ROW_REG, CFG_CALIBRATED, MODE_LEFT, 9'hFF, 1'b0, NO_WANT},
        '{ROW_REG, CFG_LEFT_LIMIT, MODE_LEFT, 9'h00, 1'b0, NO_WANT},
        '{ROW_REG, CFG_UNUSED_LO,  MODE_LEFT, 9'hAA, 1'b0, NO_WANT},
        '{ROW_REG, CFG_UNUSED_HI,  MODE_LEFT, 9'h55, 1'b0, NO_WANT},
        '{ROW_REQ, KIND_MODE,   MODE_RIGHT, 9'd0,   1'b0, NO_WANT},
        '{ROW_REQ, KIND_TICK,   MODE_LEFT,  9'd0,   1'b0, NO_WANT},
        '{ROW_REQ, KIND_TICK,   MODE_LEFT,  9'd0,   1'b0, NO_WANT},
        '{ROW_REQ, KIND_MODE,   MODE_LEFT,  9'd0,   1'b0, NO_WANT},
        '{ROW_REQ, KIND_TICK,   MODE_HOLD,  9'd0,   1'b0, NO_WANT},
        '{ROW_REQ, KIND_TICK,   MODE_HOLD,  9'd0,   1'b0, NO_WANT},
        '{ROW_REQ, KIND_MOVE,   MODE_HOLD,  9'd360, 1'b0, NO_WANT},
        '{ROW_REQ, KIND_MOVE,   MODE_HOLD,  9'd511, 1'b0, NO_WANT},
        '{ROW_REQ, KIND_MOVE,   MODE_STOP,  9'd1,   1'b0, NO_WANT},
        '{ROW_REG, CFG_CALIBRATED, MODE_LEFT, 9'hFE, 1'b0, NO_WANT},
        '{ROW_REG, CFG_LEFT_LIMIT, MODE_LEFT, 9'd180, 1'b0, NO_WANT},
        '{ROW_REQ, KIND_TICK,   MODE_RIGHT, 9'd0,   1'b0, NO_WANT}
    };

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    hss_cmd_if cmd_ch();
    hss_status_if status_ch();

    half_step_stepper_sequencer dut (
        .clk(clk),
        .rst_n(rst_n),
        .cmd(cmd_ch),
        .status(status_ch),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    // Motor state as the block should hold it.
    logic                cal_on = 1'b0;
    logic [7:0]          left_limit = LEFT_LIMIT_RESET;
    logic                motor_running = 1'b0;
    mode_t               motor_dir = MODE_RIGHT;
    logic [2:0]          motor_phase = 3'd0;
    logic signed [12:0]  motor_pos = 13'sd0;
    logic                move_armed = 1'b0;
    logic [12:0]         move_count = 13'd0;
    logic [8:0]          move_goal = 9'd0;
    logic [3:0]          coil_drive = 4'h0;

    motor_status_t status_due [$];
    int mismatches = 0;
    bit idling = 1'b1;
    bit cfg_we_high = 1'b0;
    int stall_left = 0;
    int quiet_cycles = 0;

    initial clk = 1'b0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Counts one step of an angle move and ends the move once far enough.
    function automatic logic count_move_step();
        if (!move_armed)
            return 1'b0;
        if (move_count < STEPS_MAX)
            move_count = move_count + 13'd1;
        if (int'(move_count) * 180 >= int'(move_goal) * HALF_STEPS_DEFAULT)
        begin
            move_count = 13'd0;
            move_armed = 1'b0;
            coil_drive = 4'h0;
            motor_running = 1'b0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic motor_status_t advance_motor(input logic [1:0] kind, input mode_t mode,
                                                    input logic [8:0] angle);
        motor_status_t res;
        logic finished;
        finished = 1'b0;
        case (kind)
            KIND_TICK:
            begin
                if (motor_running)
                begin
                    if (motor_dir == MODE_RIGHT && motor_pos >= 0)
                    begin
                        coil_drive = CW_PATTERN[motor_phase];
                        motor_phase = motor_phase + 3'd1;
                        if (!cal_on)
                            motor_pos = 13'sd0;
                        else if (motor_pos > POS_MIN)
                            motor_pos = motor_pos - 13'sd1;
                        finished = count_move_step();
                    end
                    else if (motor_dir == MODE_LEFT &&
                             int'(motor_pos) * 180 < int'(left_limit) * HALF_STEPS_DEFAULT)
                    begin
                        coil_drive = CCW_PATTERN[motor_phase];
                        motor_phase = motor_phase + 3'd1;
                        if (motor_pos < POS_MAX)
                            motor_pos = motor_pos + 13'sd1;
                        finished = count_move_step();
                    end
                end
                else if (motor_dir == MODE_STOP)
                begin
                    coil_drive = 4'h0;
                end
            end
            KIND_MODE:
            begin
                motor_dir = mode;
                if (!motor_running && (mode == MODE_LEFT || mode == MODE_RIGHT))
                    motor_running = 1'b1;
                else if (motor_running && mode == MODE_STOP)
                    motor_running = 1'b0;
            end
            KIND_MOVE:
            begin
                move_goal = angle;
                move_armed = 1'b1;
            end
            default:
            begin
            end
        endcase
        res.coils = coil_drive;
        res.position = motor_pos;
        res.running = motor_running;
        res.move_done = finished;
        return res;
    endfunction

    task automatic send_request(input logic [1:0] kind, input mode_t mode,
                                input logic [8:0] angle, input logic typed,
                                input motor_status_t want);
        motor_status_t due;
        if (cfg_we_high)
        begin
            cfg_we <= 1'b0;
            cfg_we_high = 1'b0;
        end
        if (idling && $urandom_range(0, 5) == 0)
        begin
            cmd_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        cmd_ch.valid <= 1'b1;
        cmd_ch.kind <= kind;
        cmd_ch.mode <= mode;
        cmd_ch.angle_deg <= angle;
        do
            @(posedge clk);
        while (!cmd_ch.ready);
        due = advance_motor(kind, mode, angle);
        if (typed)
            due = want;
        status_due.push_back(due);
    endtask

    // Register writes only go in once every pending status has come back.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] data);
        cmd_ch.valid <= 1'b0;
        while (status_due.size() != 0)
            @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        cfg_we_high = 1'b1;
        @(posedge clk);
        case (idx)
            CFG_CALIBRATED: cal_on = data[0];
            CFG_LEFT_LIMIT: left_limit = data;
            default:
            begin
            end
        endcase
    endtask

    always @(posedge clk)
    begin
        motor_status_t want;
        if (!rst_n)
        begin
            status_ch.ready <= 1'b0;
        end
        else
        begin
            if (status_ch.valid && status_ch.ready)
            begin
                if (status_due.size() == 0)
                begin
                    $error("status with no request pending: coils %0h position %0d",
                           status_ch.coils, status_ch.position);
                    mismatches++;
                end
                else
                begin
                    want = status_due.pop_front();
                    if (status_ch.coils !== want.coils)
                    begin
                        $error("coils: expected %0h, got %0h", want.coils, status_ch.coils);
                        mismatches++;
                    end
                    if (status_ch.position !== want.position)
                    begin
                        $error("position: expected %0d, got %0d",
                               want.position, status_ch.position);
                        mismatches++;
                    end
                    if (status_ch.running !== want.running)
                    begin
                        $error("running: expected %0b, got %0b",
                               want.running, status_ch.running);
                        mismatches++;
                    end
                    if (status_ch.move_done !== want.move_done)
                    begin
                        $error("move_done: expected %0b, got %0b",
                               want.move_done, status_ch.move_done);
                        mismatches++;
                    end
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                status_ch.ready <= 1'b0;
            end
            else if (idling && $urandom_range(0, 7) == 0)
            begin
                stall_left = $urandom_range(1, 13) - 1;
                status_ch.ready <= 1'b0;
            end
            else
            begin
                status_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((cmd_ch.valid && cmd_ch.ready) || (status_ch.valid && status_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles == QUIET_LIMIT)
            begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    initial
    begin
        int r;
        logic [1:0] kind;
        mode_t mode;
        logic [8:0] angle;
        logic [7:0] limit_val;

        rst_n <= 1'b0;
        cmd_ch.valid <= 1'b0;
        cmd_ch.kind <= KIND_TICK;
        cmd_ch.mode <= MODE_RIGHT;
        cmd_ch.angle_deg <= 9'd0;
        cfg_we <= 1'b0;
        cfg_index <= CFG_CALIBRATED;
        cfg_data <= 8'd0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        foreach (PLAN[n])
        begin
            if (PLAN[n].what == ROW_REG)
                write_reg(PLAN[n].code, PLAN[n].value[7:0]);
            else
                send_request(PLAN[n].code, PLAN[n].mode, PLAN[n].value,
                             PLAN[n].typed, PLAN[n].want);
        end

        for (int p = 0; p < N_PHASES; p++)
        begin
            limit_val = (p == N_PHASES - 1) ? 8'($urandom_range(0, 180)) : PHASE_LIMIT[p];
            write_reg(CFG_CALIBRATED, {7'd0, PHASE_CAL[p]});
            write_reg(CFG_LEFT_LIMIT, limit_val);
            idling = (p != N_PHASES - 1);
            for (int i = 0; i < PHASE_REQUESTS; i++)
            begin
                // Mostly ticks after a start, with short angle moves mixed in so
                // that moves complete; fields a request ignores are left random.
                r = $urandom_range(0, 99);
                mode = mode_t'($urandom_range(0, 3));
                angle = 9'($urandom_range(0, 511));
                if (r < 60)
                begin
                    kind = KIND_TICK;
                end
                else if (r < 76)
                begin
                    kind = KIND_MODE;
                    mode = ($urandom_range(0, 1) == 0) ? MODE_LEFT : MODE_RIGHT;
                end
                else if (r < 84)
                begin
                    kind = KIND_MOVE;
                    if ($urandom_range(0, 9) != 0)
                        angle = 9'($urandom_range(0, 6));
                end
                else if (r < 90)
                begin
                    kind = KIND_MODE;
                    mode = MODE_STOP;
                end
                else if (r < 95)
                begin
                    kind = KIND_MODE;
                    mode = MODE_HOLD;
                end
                else
                begin
                    kind = KIND_UNUSED;
                end
                send_request(kind, mode, angle, 1'b0, NO_WANT);
            end
        end

        cmd_ch.valid <= 1'b0;
        while (status_due.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

`default_nettype wire
